// ----- rtl/ucf_pkg.sv -----
// shared types and constants for the utf-8 decoder with case folding
package ucf_pkg;

  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int CP_W    = 31;

  localparam logic [CP_W-1:0] CH_TAB   = CP_W'(32'h09);
  localparam logic [CP_W-1:0] CH_NL    = CP_W'(32'h0A);
  localparam logic [CP_W-1:0] CH_SPACE = CP_W'(32'h20);
  localparam logic [CP_W-1:0] CH_SEMI  = CP_W'(32'h3B);
  localparam logic [CP_W-1:0] CH_BSL   = CP_W'(32'h5C);
  localparam logic [CP_W-1:0] CH_LA    = CP_W'(32'h61);
  localparam logic [CP_W-1:0] CH_LZ    = CP_W'(32'h7A);
  localparam logic [CP_W-1:0] CH_BAR   = CP_W'(32'h7C);
  localparam logic [CP_W-1:0] CASE_OFS = CP_W'(32'h20);

  // what the front hands to the back
  typedef enum logic [2:0] {
    ENT_CHAR    = 3'd0,
    ENT_TAB     = 3'd1,
    ENT_ERR     = 3'd2,
    ENT_END_ERR = 3'd3,
    ENT_END     = 3'd4
  } ent_kind_t;

  typedef enum logic [2:0] {
    MODE_NORMAL    = 3'd0,
    MODE_BACKSLASH = 3'd1,
    MODE_VBAR      = 3'd2,
    MODE_VBAR_BSL  = 3'd3,
    MODE_COMMENT   = 3'd4
  } mode_t;

  typedef struct packed {
    ent_kind_t        kind;
    logic [CP_W-1:0]  cp;
  } ucf_entry_t;

  typedef struct packed {
    logic       valid;
    ucf_entry_t entry;
  } ucf_push_t;

  typedef struct packed {
    logic       valid;
    ucf_entry_t entry;
  } ucf_head_t;

endpackage

// ----- rtl/ucf_front.sv -----
// front part: assembles utf-8 bytes into code points and classifies them
module ucf_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      in_data_byte,
  input  logic            in_end_of_input,
  input  logic            q_full,
  output ucf_pkg::ucf_push_t push
);
  import ucf_pkg::*;

  logic [CP_W-1:0] partial_value_r, partial_value_nxt;
  logic [2:0]      bytes_pending_r, bytes_pending_nxt;
  logic            accept;
  logic [CP_W-1:0] joined;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign joined   = {partial_value_r[CP_W-7:0], in_data_byte[5:0]};

  always_comb begin
    partial_value_nxt = partial_value_r;
    bytes_pending_nxt = bytes_pending_r;
    push.valid        = 1'b0;
    push.entry.kind   = ENT_CHAR;
    push.entry.cp     = '0;
    if (accept) begin
      if (in_end_of_input) begin
        partial_value_nxt = '0;
        bytes_pending_nxt = '0;
        push.valid        = 1'b1;
        push.entry.kind   = (bytes_pending_r != 3'd0) ? ENT_END_ERR : ENT_END;
      end else if (bytes_pending_r != 3'd0) begin
        if (in_data_byte[7:6] != 2'b10) begin
          // bad continuation word is swallowed
          partial_value_nxt = '0;
          bytes_pending_nxt = '0;
          push.valid        = 1'b1;
          push.entry.kind   = ENT_ERR;
        end else if (bytes_pending_r == 3'd1) begin
          partial_value_nxt = '0;
          bytes_pending_nxt = '0;
          push.valid        = 1'b1;
          push.entry.cp     = joined;
          push.entry.kind   = (joined == CH_TAB) ? ENT_TAB : ENT_CHAR;
        end else begin
          partial_value_nxt = joined;
          bytes_pending_nxt = bytes_pending_r - 3'd1;
        end
      end else begin
        priority if (in_data_byte < 8'h80) begin
          push.valid      = 1'b1;
          push.entry.cp   = CP_W'(in_data_byte);
          push.entry.kind = (CP_W'(in_data_byte) == CH_TAB) ? ENT_TAB : ENT_CHAR;
        end else if (in_data_byte < 8'hC0) begin
          push.valid      = 1'b1;
          push.entry.kind = ENT_ERR;
        end else if (in_data_byte < 8'hE0) begin
          partial_value_nxt = CP_W'(in_data_byte[4:0]);
          bytes_pending_nxt = 3'd1;
        end else if (in_data_byte < 8'hF0) begin
          partial_value_nxt = CP_W'(in_data_byte[3:0]);
          bytes_pending_nxt = 3'd2;
        end else if (in_data_byte < 8'hF8) begin
          partial_value_nxt = CP_W'(in_data_byte[2:0]);
          bytes_pending_nxt = 3'd3;
        end else if (in_data_byte < 8'hFC) begin
          partial_value_nxt = CP_W'(in_data_byte[1:0]);
          bytes_pending_nxt = 3'd4;
        end else if (in_data_byte < 8'hFE) begin
          partial_value_nxt = CP_W'(in_data_byte[0]);
          bytes_pending_nxt = 3'd5;
        end else begin
          push.valid      = 1'b1;
          push.entry.kind = ENT_ERR;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      partial_value_r <= '0;
      bytes_pending_r <= '0;
    end else begin
      partial_value_r <= partial_value_nxt;
      bytes_pending_r <= bytes_pending_nxt;
    end
  end

endmodule

// ----- rtl/ucf_queue.sv -----
// short fifo between the decoder front and the lexer back
module ucf_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  ucf_pkg::ucf_push_t push,
  input  logic               pop,
  output logic               full,
  output ucf_pkg::ucf_head_t head
);
  import ucf_pkg::*;

  ucf_entry_t       mem_r [Q_DEPTH];
  logic [Q_AW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [Q_AW:0]    cnt_r, cnt_nxt;

  assign full       = (cnt_r == (Q_AW+1)'(Q_DEPTH));
  assign head.valid = (cnt_r != '0);
  assign head.entry = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push.valid && !pop) cnt_nxt = cnt_r + 1'b1;
    else if (!push.valid && pop) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (push.valid) mem_r[wr_ptr_r] <= push.entry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push.valid) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)        rd_ptr_r <= rd_ptr_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push.valid |-> !full) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head.valid) else $error("queue underflow");
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (Q_AW+1)'(Q_DEPTH)) else $error("queue count out of range");
  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0) |-> (wr_ptr_r == rd_ptr_r)) else $error("pointers disagree");

endmodule

// ----- rtl/ucf_back.sv -----
// back part: lexical modes, case folding and the output register
module ucf_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ucf_pkg::ucf_head_t    head,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [ucf_pkg::CP_W-1:0] out_code_point,
  output logic                  out_bad_sequence
);
  import ucf_pkg::*;

  mode_t           mode_r, mode_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [CP_W-1:0] out_cp_r, out_cp_nxt;
  logic            out_bad_r, out_bad_nxt;
  logic [CP_W-1:0] c;

  assign pop              = head.valid && (!out_valid_r || out_ready);
  assign c                = head.entry.cp;
  assign out_valid        = out_valid_r;
  assign out_code_point   = out_cp_r;
  assign out_bad_sequence = out_bad_r;

  always_comb begin
    mode_nxt      = mode_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_cp_nxt    = out_cp_r;
    out_bad_nxt   = out_bad_r;
    if (pop) begin
      unique case (head.entry.kind)
        ENT_TAB: begin
          out_valid_nxt = 1'b1;
          out_cp_nxt    = CH_SPACE;
          out_bad_nxt   = 1'b0;
        end
        ENT_ERR: begin
          out_valid_nxt = 1'b1;
          out_cp_nxt    = '0;
          out_bad_nxt   = 1'b1;
        end
        ENT_END_ERR: begin
          out_valid_nxt = 1'b1;
          out_cp_nxt    = '0;
          out_bad_nxt   = 1'b1;
          mode_nxt      = MODE_NORMAL;
        end
        ENT_END: begin
          mode_nxt = MODE_NORMAL;
        end
        ENT_CHAR: begin
          out_valid_nxt = 1'b1;
          out_cp_nxt    = c;
          out_bad_nxt   = 1'b0;
          unique case (mode_r)
            MODE_BACKSLASH: mode_nxt = MODE_NORMAL;
            MODE_VBAR: begin
              priority if (c == CH_BSL) mode_nxt = MODE_VBAR_BSL;
              else if (c == CH_BAR) mode_nxt = MODE_NORMAL;
              else mode_nxt = MODE_VBAR;
            end
            MODE_VBAR_BSL: mode_nxt = MODE_VBAR;
            MODE_COMMENT: begin
              if (c == CH_NL) mode_nxt = MODE_NORMAL;
            end
            default: begin
              mode_nxt = MODE_NORMAL;
              priority if (c >= CH_LA && c <= CH_LZ) out_cp_nxt = c - CASE_OFS;
              else if (c == CH_BSL) mode_nxt = MODE_BACKSLASH;
              else if (c == CH_BAR) mode_nxt = MODE_VBAR;
              else if (c == CH_SEMI) mode_nxt = MODE_COMMENT;
              else mode_nxt = MODE_NORMAL;
            end
          endcase
        end
        default: begin
          out_valid_nxt = out_valid_r && !out_ready;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_NORMAL;
      out_valid_r <= 1'b0;
    end else begin
      mode_r      <= mode_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_cp_r  <= out_cp_nxt;
    out_bad_r <= out_bad_nxt;
  end

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_bad_r) |-> (out_cp_r == '0)) else $error("error word not zero");
  a_pop_free: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (!out_valid_r || out_ready)) else $error("pop into a full output stage");
  a_end_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && (head.entry.kind == ENT_END || head.entry.kind == ENT_END_ERR))
      |=> (mode_r == MODE_NORMAL)) else $error("end did not clear lexer mode");

endmodule

// ----- rtl/utf8_decode_with_case_fold_unit.sv -----
// top level of the utf-8 decoder with lexical case folding
// Input channel: one byte per word (in_data_byte), or an end marker when
// in_end_of_input is set; in_valid/in_ready handshake. Result channel: one
// code point per word on out_code_point with out_bad_sequence, out_valid/out_ready.
// A byte that only extends a multi-byte sequence yields no result word; an
// end marker yields a result word only when it cuts a sequence short (error).
// A result word passes from the decoder front through the four-entry queue and
// the lexer back into the output register. Throughput: one byte per cycle while
// out_ready is high; the lexer back retires one queue entry per cycle while
// the output register is free or read; in_ready drops only when the queue is full.
// When the receiver stalls, the output register holds its word and the queue
// absorbs up to four further entries before in_ready falls.
// Reset (rst_n low, synchronous) empties the queue, clears the partial code
// point and pending-byte count and sets the lexer to normal mode.
// Tab goes out as space; lowercase ascii is folded to uppercase only in normal
// mode; errors come out as code point 0 with out_bad_sequence set.
module utf8_decode_with_case_fold_unit (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [7:0]               in_data_byte,
  input  logic                     in_end_of_input,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [ucf_pkg::CP_W-1:0] out_code_point,
  output logic                     out_bad_sequence
);
  import ucf_pkg::*;

  ucf_push_t push;
  ucf_head_t head;
  logic      q_full;
  logic      pop;

  ucf_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data_byte    (in_data_byte),
    .in_end_of_input (in_end_of_input),
    .q_full          (q_full),
    .push            (push)
  );

  ucf_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (pop),
    .full  (q_full),
    .head  (head)
  );

  ucf_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head             (head),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_code_point   (out_code_point),
    .out_bad_sequence (out_bad_sequence)
  );

endmodule

// ----- tb/sv/utf8_case_fold_checker.sv -----
// watches both channels, predicts decoded characters and compares result words
module utf8_case_fold_checker (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic                     in_ready,
  input  logic [7:0]               in_data_byte,
  input  logic                     in_end_of_input,
  input  logic                     out_valid,
  input  logic                     out_ready,
  input  logic [ucf_pkg::CP_W-1:0] out_code_point,
  input  logic                     out_bad_sequence,
  output int                       fail_count,
  output int                       words_expected
);
  import ucf_pkg::*;

  typedef struct packed {
    logic [CP_W-1:0] cp;
    logic            bad;
  } char_word_t;

  char_word_t      expected_chars[$];
  logic [CP_W-1:0] gathered;
  logic [2:0]      cont_left;
  mode_t           lex_mode;

  initial fail_count = 0;
  initial words_expected = 0;

  task automatic report_mismatch(input string msg);
    fail_count++;
    if (fail_count <= 50) $display("mismatch: %s", msg);
  endtask

  task automatic queue_word(input logic [CP_W-1:0] cp, input logic bad);
    expected_chars.push_back(char_word_t'{cp: cp, bad: bad});
  endtask

  // tab bypasses the lexer, everything else steps it
  task automatic fold_and_queue(input logic [CP_W-1:0] c);
    logic [CP_W-1:0] r;
    r = c;
    if (c == CH_TAB) begin
      r = CH_SPACE;
    end else begin
      case (lex_mode)
        MODE_BACKSLASH: lex_mode = MODE_NORMAL;
        MODE_VBAR: begin
          if (c == CH_BSL) lex_mode = MODE_VBAR_BSL;
          else if (c == CH_BAR) lex_mode = MODE_NORMAL;
        end
        MODE_VBAR_BSL: lex_mode = MODE_VBAR;
        MODE_COMMENT: begin
          if (c == CH_NL) lex_mode = MODE_NORMAL;
        end
        default: begin
          lex_mode = MODE_NORMAL;
          if (c >= CH_LA && c <= CH_LZ) r = c - CASE_OFS;
          else if (c == CH_BSL) lex_mode = MODE_BACKSLASH;
          else if (c == CH_BAR) lex_mode = MODE_VBAR;
          else if (c == CH_SEMI) lex_mode = MODE_COMMENT;
        end
      endcase
    end
    queue_word(r, 1'b0);
  endtask

  always @(posedge clk) begin : watch
    char_word_t want;
    if (!rst_n) begin
      expected_chars.delete();
      gathered  = '0;
      cont_left = '0;
      lex_mode  = MODE_NORMAL;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_chars.size() == 0) begin
          report_mismatch($sformatf("unexpected word cp=%h bad=%b",
                                    out_code_point, out_bad_sequence));
        end else begin
          want = expected_chars.pop_front();
          if (out_code_point !== want.cp)
            report_mismatch($sformatf("code point %h, wanted %h", out_code_point, want.cp));
          if (out_bad_sequence !== want.bad)
            report_mismatch($sformatf("bad flag %b, wanted %b (cp %h)",
                                      out_bad_sequence, want.bad, want.cp));
        end
      end
      if (in_valid && in_ready) begin
        if (in_end_of_input) begin
          // end marker only reports when it cuts a sequence short
          if (cont_left != 3'd0) queue_word('0, 1'b1);
          gathered  = '0;
          cont_left = '0;
          lex_mode  = MODE_NORMAL;
        end else if (cont_left != 3'd0) begin
          if (in_data_byte[7:6] != 2'b10) begin
            gathered  = '0;
            cont_left = '0;
            queue_word('0, 1'b1);
          end else begin
            gathered  = {gathered[CP_W-7:0], in_data_byte[5:0]};
            cont_left = cont_left - 3'd1;
            if (cont_left == 3'd0) begin
              fold_and_queue(gathered);
              gathered = '0;
            end
          end
        end else if (in_data_byte < 8'h80) begin
          fold_and_queue(CP_W'(in_data_byte));
        end else if (in_data_byte < 8'hC0) begin
          queue_word('0, 1'b1);
        end else if (in_data_byte < 8'hE0) begin
          gathered  = CP_W'(in_data_byte[4:0]);
          cont_left = 3'd1;
        end else if (in_data_byte < 8'hF0) begin
          gathered  = CP_W'(in_data_byte[3:0]);
          cont_left = 3'd2;
        end else if (in_data_byte < 8'hF8) begin
          gathered  = CP_W'(in_data_byte[2:0]);
          cont_left = 3'd3;
        end else if (in_data_byte < 8'hFC) begin
          gathered  = CP_W'(in_data_byte[1:0]);
          cont_left = 3'd4;
        end else if (in_data_byte < 8'hFE) begin
          gathered  = CP_W'(in_data_byte[0]);
          cont_left = 3'd5;
        end else begin
          queue_word('0, 1'b1);
        end
      end
    end
    words_expected = expected_chars.size();
  end

endmodule

// ----- tb/sv/tb_utf8_decode_with_case_fold_unit.sv -----
// stimulus, clock, reset and verdict for the utf-8 decoder with case folding
module tb_utf8_decode_with_case_fold_unit;
  import ucf_pkg::*;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            in_valid = 1'b0;
  logic            in_ready;
  logic [7:0]      in_data_byte = 8'h00;
  logic            in_end_of_input = 1'b0;
  logic            out_valid;
  logic            out_ready = 1'b0;
  logic [CP_W-1:0] out_code_point;
  logic            out_bad_sequence;

  int fail_count;
  int words_expected;
  int sent_items = 0;
  bit no_idle = 1'b0;
  bit hold_req = 1'b0;

  always #5 clk = ~clk;

  utf8_decode_with_case_fold_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .in_end_of_input  (in_end_of_input),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_code_point   (out_code_point),
    .out_bad_sequence (out_bad_sequence)
  );

  utf8_case_fold_checker checker_i (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .in_end_of_input  (in_end_of_input),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_code_point   (out_code_point),
    .out_bad_sequence (out_bad_sequence),
    .fail_count       (fail_count),
    .words_expected   (words_expected)
  );

  // entered and left at a falling edge
  task automatic send_word(input logic [7:0] b, input logic eoi);
    while (!no_idle && $urandom_range(99) < 15) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_data_byte    <= b;
    in_end_of_input <= eoi;
    do @(posedge clk); while (!in_ready);
    sent_items++;
    @(negedge clk);
  endtask

  // ascii biased toward the characters that steer the lexer
  function automatic logic [7:0] pick_ascii();
    case ($urandom_range(9))
      0: return CH_BAR[7:0];
      1: return CH_BSL[7:0];
      2: return CH_SEMI[7:0];
      3: return CH_NL[7:0];
      4: return CH_TAB[7:0];
      5, 6: return 8'($urandom_range(CH_LA[7:0], CH_LZ[7:0]));
      default: return 8'($urandom_range(8'h7F));
    endcase
  endfunction

  // multi-byte sequence of len bytes; a broken one stops early and is spoiled
  task automatic send_sequence(input int len, input bit broken);
    logic [7:0] lead;
    int         conts;
    lead = 8'($urandom_range(255));
    case (len)
      2: lead[7:5] = 3'b110;
      3: lead[7:4] = 4'b1110;
      4: lead[7:3] = 5'b11110;
      5: lead[7:2] = 6'b111110;
      default: lead[7:1] = 7'b1111110;
    endcase
    conts = broken ? $urandom_range(len - 2) : len - 1;
    send_word(lead, 1'b0);
    repeat (conts) send_word({2'b10, 6'($urandom_range(63))}, 1'b0);
    if (broken) begin
      case ($urandom_range(2))
        0: send_word(8'($urandom_range(255)), 1'b1);
        1: send_word(pick_ascii(), 1'b0);
        default: send_word(8'($urandom_range(8'hFF, 8'hC0)), 1'b0);
      endcase
    end
  endtask

  task automatic send_token();
    int pick;
    int len;
    pick = $urandom_range(99);
    len  = ($urandom_range(99) < 55) ? 2 : $urandom_range(6, 3);
    if (pick < 45) send_word(pick_ascii(), 1'b0);
    else if (pick < 73) send_sequence(len, 1'b0);
    else if (pick < 83) send_sequence(len, 1'b1);
    else if (pick < 88) send_word(8'($urandom_range(255)), 1'b1);
    else send_word(8'($urandom_range(255)), 1'b0);
  endtask

  initial begin : receiver
    int hold_cnt;
    bit hold_used;
    hold_cnt  = 0;
    hold_used = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_used) begin
        hold_used = 1'b1;
        hold_cnt  = 80;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_ready <= 1'b0;
      end else if (no_idle) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= 15);
      end
    end
  end

  initial begin
    #2000000;
    $display("utf8_decode_with_case_fold_unit regression: fail");
    $finish;
  end

  initial begin : stimulus
    logic [7:0] directed[$];
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // folding, tab, escape, bars with escaped bar, comment, errors, longest sequence
    directed = '{8'h7F, 8'h61, 8'h09, 8'h5C, 8'h61, 8'h7C, 8'h5C, 8'h7C, 8'h7C,
                 8'h3B, 8'h61, 8'h0A, 8'h80, 8'hFF, 8'hC3, 8'h41, 8'hFD,
                 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hE2, 8'h82};
    foreach (directed[i]) send_word(directed[i], 1'b0);
    // end marker mid-sequence, then with nothing pending
    send_word(8'h00, 1'b1);
    send_word(8'hFF, 1'b1);

    while (sent_items < 520) send_token();
    // long receiver hold-off while words keep coming
    hold_req = 1'b1;
    while (sent_items < 720) send_token();
    no_idle = 1'b1;
    while (sent_items < 1020) send_token();
    no_idle = 1'b0;

    // sender pause until every word has drained
    in_valid <= 1'b0;
    wait (words_expected == 0);
    @(negedge clk);

    while (sent_items < 1475) send_token();
    in_valid <= 1'b0;

    wait (words_expected == 0);
    repeat (20) @(negedge clk);
    if (fail_count == 0 && words_expected == 0) begin
      $display("utf8_decode_with_case_fold_unit regression: pass");
    end else begin
      $display("utf8_decode_with_case_fold_unit regression: fail");
    end
    $finish;
  end

endmodule
